/* rtl/smtd_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the sync-marker TLV deframer.
// No dependencies; imported by sync_marker_tlv_deframer.
`default_nettype none

package smtd_pkg;

   localparam logic [7:0]  SYNC_BYTE0      = 8'h37;
   localparam logic [7:0]  SYNC_BYTE1      = 8'h38;
   localparam logic [7:0]  SYNC_BYTE2      = 8'h36;
   localparam logic [1:0]  LEN_BYTE_LAST   = 2'd3;
   localparam logic [15:0] MAX_LENGTH_RST  = 16'd1024;

   typedef struct packed {
      logic [7:0]  tag;
      logic [7:0]  data_byte;
      logic [15:0] byte_offset;
      logic        last;
      logic        empty_frame;
      logic        length_error;
   } rsp_beat_type;

endpackage

`default_nettype wire

/* rtl/sync_marker_tlv_deframer.sv */
`timescale 1ns / 1ps
// Sync-marker TLV deframer: hunts for "786", reads tag and 4-byte LE length,
// emits one beat per payload byte, or a flag beat for an empty or too-long frame.
// Depends on smtd_pkg. Beats are registered; 1 byte per cycle unless req_stall.
// Other header and unmatched bytes give no beat. A two-entry output stage (result
// register plus skid register) keeps input flowing while a result waits.
// Synchronous active-high reset: hunting, max_length = 1024, both stages empty.
`default_nettype none

module sync_marker_tlv_deframer
   import smtd_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_wr_en,
   input  wire logic [15:0] csr_wr_data,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_rx_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [7:0]       rsp_tag,
   output logic [7:0]       rsp_data_byte,
   output logic [15:0]      rsp_byte_offset,
   output logic             rsp_last,
   output logic             rsp_empty_frame,
   output logic             rsp_length_error
);

   typedef enum logic [2:0] {
      PH_HUNT0,
      PH_HUNT1,
      PH_HUNT2,
      PH_TAG,
      PH_LEN,
      PH_DATA
   } phase_type;

   phase_type    phase_ff, phase_in;
   logic [15:0]  max_length_ff;
   logic [7:0]   tag_ff, tag_in;
   logic [15:0]  len_ff, len_in;
   logic         len_hi_ff, len_hi_in;
   logic [1:0]   hdr_cnt_ff, hdr_cnt_in;
   logic [15:0]  pay_cnt_ff, pay_cnt_in;

   logic         out_valid_ff, skid_valid_ff;
   rsp_beat_type out_ff, skid_ff;

   logic         accept, take, new_valid, data_last;
   rsp_beat_type new_beat;
   logic [16:0]  pay_next;

   assign accept   = req_valid && !req_stall;
   assign take     = out_valid_ff && !rsp_stall;
   assign pay_next = {1'b0, pay_cnt_ff} + 17'd1;
   assign data_last = pay_next >= {1'b0, len_ff};

   always_comb begin
      phase_in   = phase_ff;
      tag_in     = tag_ff;
      len_in     = len_ff;
      len_hi_in  = len_hi_ff;
      hdr_cnt_in = hdr_cnt_ff;
      pay_cnt_in = pay_cnt_ff;
      new_valid  = 1'b0;
      new_beat   = '{tag: tag_ff, data_byte: 8'd0, byte_offset: 16'd0,
                     last: 1'b1, empty_frame: 1'b0, length_error: 1'b0};
      case (phase_ff)
         PH_HUNT1: begin
            if (req_rx_byte == SYNC_BYTE1) phase_in = PH_HUNT2;
            else phase_in = (req_rx_byte == SYNC_BYTE0) ? PH_HUNT1 : PH_HUNT0;
         end
         PH_HUNT2: begin
            if (req_rx_byte == SYNC_BYTE2) phase_in = PH_TAG;
            else phase_in = (req_rx_byte == SYNC_BYTE0) ? PH_HUNT1 : PH_HUNT0;
         end
         PH_TAG: begin
            tag_in     = req_rx_byte;
            len_in     = 16'd0;
            len_hi_in  = 1'b0;
            hdr_cnt_in = 2'd0;
            phase_in   = PH_LEN;
         end
         PH_LEN: begin
            case (hdr_cnt_ff)
               2'd0:    len_in[7:0]  = req_rx_byte;
               2'd1:    len_in[15:8] = req_rx_byte;
               default: len_hi_in    = len_hi_ff || (req_rx_byte != 8'd0);
            endcase
            if (hdr_cnt_ff != LEN_BYTE_LAST) begin
               hdr_cnt_in = hdr_cnt_ff + 2'd1;
            end else begin
               hdr_cnt_in = 2'd0;
               pay_cnt_in = 16'd0;
               if (!len_hi_in && len_ff == 16'd0) begin
                  phase_in              = PH_HUNT0;
                  new_valid             = 1'b1;
                  new_beat.empty_frame  = 1'b1;
               end else if (len_hi_in || len_ff > max_length_ff) begin
                  phase_in              = PH_HUNT0;
                  new_valid             = 1'b1;
                  new_beat.length_error = 1'b1;
               end else begin
                  phase_in = PH_DATA;
               end
            end
         end
         PH_DATA: begin
            new_valid            = 1'b1;
            new_beat.data_byte   = req_rx_byte;
            new_beat.byte_offset = pay_cnt_ff;
            new_beat.last        = data_last;
            if (data_last) begin
               phase_in   = PH_HUNT0;
               pay_cnt_in = 16'd0;
            end else begin
               pay_cnt_in = pay_next[15:0];
            end
         end
         default: begin
            phase_in = (req_rx_byte == SYNC_BYTE0) ? PH_HUNT1 : PH_HUNT0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_HUNT0;
         max_length_ff <= MAX_LENGTH_RST;
         tag_ff        <= 8'd0;
         len_ff        <= 16'd0;
         len_hi_ff     <= 1'b0;
         hdr_cnt_ff    <= 2'd0;
         pay_cnt_ff    <= 16'd0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) max_length_ff <= csr_wr_data;
         if (accept) begin
            phase_ff   <= phase_in;
            tag_ff     <= tag_in;
            len_ff     <= len_in;
            len_hi_ff  <= len_hi_in;
            hdr_cnt_ff <= hdr_cnt_in;
            pay_cnt_ff <= pay_cnt_in;
         end
         if (skid_valid_ff) begin
            if (take) begin
               out_ff        <= skid_ff;
               skid_valid_ff <= 1'b0;
            end
         end else if (accept && new_valid && out_valid_ff && !take) begin
            skid_ff       <= new_beat;
            skid_valid_ff <= 1'b1;
         end else if (!out_valid_ff || take) begin
            out_valid_ff <= accept && new_valid;
            out_ff       <= new_beat;
         end
      end
   end

   assign req_stall        = skid_valid_ff;
   assign rsp_valid        = out_valid_ff;
   assign rsp_tag          = out_ff.tag;
   assign rsp_data_byte    = out_ff.data_byte;
   assign rsp_byte_offset  = out_ff.byte_offset;
   assign rsp_last         = out_ff.last;
   assign rsp_empty_frame  = out_ff.empty_frame;
   assign rsp_length_error = out_ff.length_error;

   a_skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid holds a beat while the result register is empty");

   a_stalled_beat_held: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(out_ff)))
      else $error("stalled result beat changed");

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_empty_frame || rsp_length_error)
         |-> (rsp_last && rsp_data_byte == 8'd0 && rsp_byte_offset == 16'd0
              && !(rsp_empty_frame && rsp_length_error)))
      else $error("empty or error beat carries data");

   a_data_phase_bounded: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_DATA) |-> (pay_cnt_ff < len_ff && !len_hi_ff))
      else $error("payload count ran past frame length");

endmodule

`default_nettype wire
